[hw/rtl/ikcht_pkg.sv]
`default_nettype none

package ikcht_pkg;

    // Default sizes of the table.
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int BUCKETS_DEF     = 512;
    localparam int VALUE_BITS_DEF  = 32;

    // Fixed widths of the ports.
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 7;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

    // Command codes carried by a word.
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_QUERY  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_FULL = 2'd1,
        RES_DUP  = 2'd2,
        RES_MISS = 2'd3
    } t_res;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_HEAD,
        S_HEADW,
        S_ENT,
        S_ENTW,
        S_ADD,
        S_REM,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic load;
        logic hash;
        logic mod;
        logic headw;
        logic entw;
        logic add;
        logic rem;
        logic res_load;
        t_res res_code;
        logic publish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic pow2;
        logic mod_last;
        t_op  op;
        logic full;
        logic head_nil;
        logic next_nil;
        logic match;
        logic out_busy;
    } t_sts;

    // First half of the key mix.
    function automatic logic [31:0] mix_lo(input logic [31:0] k);
        logic [31:0] t;
        t = k + (k << 12);
        t = t ^ (t >> 22);
        t = t + (t << 4);
        t = t ^ (t >> 9);
        return t;
    endfunction

    // Second half of the key mix.
    function automatic logic [31:0] mix_hi(input logic [31:0] k);
        logic [31:0] t;
        t = k + (k << 10);
        t = t ^ (t >> 2);
        t = t + (t << 7);
        t = t ^ (t >> 12);
        return t;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ikcht_ram.sv]
`default_nettype none

module ikcht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic             i_we,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/ikcht_ctrl.sv]
`default_nettype none

module ikcht_ctrl
    import ikcht_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.res_code = RES_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                if (i_sts.op == OP_NONE) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.op == OP_ADD && i_sts.full) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = RES_FULL;
                    n_state = S_DONE;
                end else if (i_sts.pow2) begin
                    n_state = S_HEAD;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                n_state = S_HEADW;
            end
            S_HEADW: begin
                o_cmd.headw = 1'b1;
                if (i_sts.head_nil) begin
                    if (i_sts.op == OP_ADD) begin
                        n_state = S_ADD;
                    end else begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = RES_MISS;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_ENT;
                end
            end
            S_ENT: begin
                n_state = S_ENTW;
            end
            S_ENTW: begin
                o_cmd.entw = 1'b1;
                if (i_sts.match) begin
                    if (i_sts.op == OP_REMOVE) begin
                        n_state = S_REM;
                    end else begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = (i_sts.op == OP_ADD) ? RES_DUP : RES_OK;
                        n_state = S_DONE;
                    end
                end else if (i_sts.next_nil) begin
                    if (i_sts.op == OP_ADD) begin
                        n_state = S_ADD;
                    end else begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = RES_MISS;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_ENT;
                end
            end
            S_ADD: begin
                o_cmd.add      = 1'b1;
                o_cmd.res_load = 1'b1;
                n_state = S_DONE;
            end
            S_REM: begin
                o_cmd.rem      = 1'b1;
                o_cmd.res_load = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/ikcht_dp.sv]
`default_nettype none

module ikcht_dp
    import ikcht_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_sts                          o_sts,
    input  wire logic                     i_cfg_we,
    input  wire logic [CNT_W-1:0]         i_cfg_data,
    input  wire logic [CMD_W-1:0]         i_command,
    input  wire logic signed [KEY_W-1:0]  i_key,
    input  wire logic [VAL_W-1:0]         i_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [1:0]                    o_status,
    output logic                          o_found,
    output logic [VAL_W-1:0]              o_found_value,
    output logic [CNT_W-1:0]              o_entry_count
);

    localparam int LW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int BW   = $clog2(BUCKETS);
    localparam int CMPW = (LW > CNT_W) ? LW : CNT_W;
    localparam bit POW2 = ((1 << BW) == BUCKETS);
    localparam logic [LW-1:0]   NIL  = LW'(MAX_ENTRIES);
    localparam logic [CMPW-1:0] MAXC = CMPW'(MAX_ENTRIES);
    localparam logic [BW:0]     BKT  = (BW+1)'(BUCKETS);

    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [VALUE_BITS-1:0] r_val, r_fval;
    logic [31:0]      r_h;
    logic [BW-1:0]    r_rem, n_rem;
    logic [2:0]       r_mcnt;
    logic [LW-1:0]    r_cur, r_prev, r_head, r_hit_next;
    logic             r_found;
    t_res             r_res;
    logic             r_used [MAX_ENTRIES];
    logic [LW-1:0]    r_count;
    logic [CNT_W-1:0] r_limit;
    logic [BW-1:0]    r_clr;

    logic [31:0]      hash_full;
    logic [IW-1:0]    free_idx, ent_addr;
    logic [BW-1:0]    head_addr;
    logic             head_we, key_we, next_we;
    logic [LW-1:0]    head_wdata, next_wdata, head_rd, next_rd;
    logic [KEY_W-1:0] key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic [CMPW-1:0]  lim_eff;
    logic [BW:0]      mod_t;

    assign hash_full = mix_hi(r_h);

    // Four remainder bits per cycle for a bucket count that is not a power of two.
    always_comb begin
        mod_t = {1'b0, r_rem};
        for (int j = 0; j < 4; j++) begin
            mod_t = {mod_t[BW-1:0], r_h[31-j]};
            if (mod_t >= BKT) begin
                mod_t = mod_t - BKT;
            end
        end
        n_rem = mod_t[BW-1:0];
    end

    // Lowest free entry.
    always_comb begin
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    // Effective limit is capped at the pool size.
    assign lim_eff = (CMPW'(r_limit) > MAXC) ? MAXC : CMPW'(r_limit);

    // Memory ports.
    assign head_addr  = i_cmd.clr ? r_clr : r_rem;
    assign head_we    = i_cmd.clr | i_cmd.add | (i_cmd.rem && r_prev == NIL);
    assign head_wdata = i_cmd.clr ? NIL : (i_cmd.add ? LW'(free_idx) : r_hit_next);
    assign ent_addr   = i_cmd.add ? free_idx : (i_cmd.rem ? r_prev[IW-1:0] : r_cur[IW-1:0]);
    assign key_we     = i_cmd.add;
    assign next_we    = i_cmd.add | (i_cmd.rem && r_prev != NIL);
    assign next_wdata = i_cmd.add ? r_head : r_hit_next;

    ikcht_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
        .i_clk(i_clk), .i_addr(head_addr), .i_we(head_we),
        .i_wdata(head_wdata), .o_rdata(head_rd)
    );

    ikcht_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key (
        .i_clk(i_clk), .i_addr(ent_addr), .i_we(key_we),
        .i_wdata(r_key), .o_rdata(key_rd)
    );

    ikcht_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_val (
        .i_clk(i_clk), .i_addr(ent_addr), .i_we(key_we),
        .i_wdata(r_val), .o_rdata(val_rd)
    );

    ikcht_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_next (
        .i_clk(i_clk), .i_addr(ent_addr), .i_we(next_we),
        .i_wdata(next_wdata), .o_rdata(next_rd)
    );

    // Status to the controller.
    always_comb begin
        o_sts.clr_last = (r_clr == BW'(BUCKETS - 1));
        o_sts.pow2     = POW2;
        o_sts.mod_last = (r_mcnt == 3'd7);
        o_sts.op       = r_op;
        o_sts.full     = (CMPW'(r_count) >= lim_eff);
        o_sts.head_nil = (head_rd == NIL);
        o_sts.next_nil = (next_rd == NIL);
        o_sts.match    = (key_rd == r_key);
        o_sts.out_busy = o_out_valid;
    end

    // Control state: occupancy, count, limit, clearing pass and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_used[i] <= 1'b0;
            end
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.add) begin
                r_used[free_idx] <= 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.rem) begin
                r_used[r_cur[IW-1:0]] <= 1'b0;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.publish) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the current word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_command);
            r_key   <= i_key;
            r_val   <= VALUE_BITS'(i_value);
            r_h     <= mix_lo(i_key);
            r_found <= 1'b0;
        end
        if (i_cmd.hash) begin
            r_h    <= hash_full;
            r_rem  <= POW2 ? hash_full[BW-1:0] : '0;
            r_mcnt <= '0;
        end
        if (i_cmd.mod) begin
            r_rem  <= n_rem;
            r_h    <= r_h << 4;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.headw) begin
            r_cur  <= head_rd;
            r_head <= head_rd;
            r_prev <= NIL;
        end
        if (i_cmd.entw) begin
            if (key_rd == r_key) begin
                r_hit_next <= next_rd;
                r_fval     <= val_rd;
                r_found    <= (r_op == OP_QUERY);
            end else begin
                r_prev <= r_cur;
                r_cur  <= next_rd;
            end
        end
        if (i_cmd.res_load) begin
            r_res <= i_cmd.res_code;
        end
        if (i_cmd.publish) begin
            o_status      <= r_res;
            o_found       <= r_found;
            o_found_value <= r_found ? VAL_W'(r_fval) : '0;
            o_entry_count <= CNT_W'(r_count);
        end
    end

endmodule

`default_nettype wire

[hw/rtl/int_key_chained_hash_table.sv]
// Each accepted word is hashed, its bucket head is read and its chain is walked entry
// by entry, with a remainder step first when BUCKETS is not a power of two; an insert or
// a removal adds an update step, while the spare command and a refused add skip the
// lookup. A waiting result adds its wait. Words are taken one at a time, the next in
// the cycle after the previous result is published. Reset is synchronous, active low;
// afterwards the bucket memory is swept to empty before the first word is accepted.
`default_nettype none

module int_key_chained_hash_table
    import ikcht_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int BUCKETS     = BUCKETS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CNT_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [CMD_W-1:0]        i_command,
    input  wire logic signed [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0]        i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_status,
    output logic                         o_found,
    output logic [VAL_W-1:0]             o_found_value,
    output logic [CNT_W-1:0]             o_entry_count
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    ikcht_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_sts(sts), .o_cmd(cmd)
    );

    // Hash, memories and result register.
    ikcht_dp #(
        .MAX_ENTRIES(MAX_ENTRIES), .BUCKETS(BUCKETS), .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_command(i_command), .i_key(i_key), .i_value(i_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_found(o_found),
        .o_found_value(o_found_value), .o_entry_count(o_entry_count)
    );

`ifndef SYNTH
    // A hit is only ever reported with status ok.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == RES_OK)
        else $error("found set with non-ok status");

    // A miss carries a zero value.
    a_zero_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_found_value == '0)
        else $error("value present without a hit");

    // The count never passes the pool size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above pool size");

    // A waiting result word stays valid and unchanged until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
        $stable(o_found) && $stable(o_found_value) && $stable(o_entry_count))
        else $error("result word changed while waiting");
`endif

endmodule

`default_nettype wire
